[src/ohlc_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, field widths and register codes for the OHLC bar resampler.
// No dependencies.
package ohlc_pkg;

  localparam int unsigned PRICE_BITS   = 32;
  localparam int unsigned VOLUME_BITS  = 48;
  localparam int unsigned TIME_BITS    = 31;
  localparam int unsigned PERIOD_BITS  = 17;
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam int unsigned CFG_DATA_BITS = 31;

  localparam logic [PERIOD_BITS-1:0] SAMPLE_PERIOD_RST = PERIOD_BITS'(60);

  // register index codes
  localparam logic [CFG_IDX_BITS-1:0] CFG_SAMPLE_PERIOD = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_START  = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_END    = CFG_IDX_BITS'(2);

  // item kinds
  localparam logic KIND_TRADE = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

endpackage

[src/ohlc_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces: trade records in, bars out, register writes.
// Depends on ohlc_pkg.
interface ohlc_rec_if;
  logic                               valid;
  logic                               ready;
  logic                               kind;
  logic [ohlc_pkg::TIME_BITS-1:0]     record_time;
  logic [ohlc_pkg::PRICE_BITS-1:0]    price;
  logic [ohlc_pkg::VOLUME_BITS-1:0]   volume;

  modport source (output valid, kind, record_time, price, volume, input ready);
  modport sink   (input valid, kind, record_time, price, volume, output ready);
endinterface

interface ohlc_bar_if;
  logic                               valid;
  logic                               ready;
  logic [ohlc_pkg::TIME_BITS-1:0]     bar_time;
  logic [ohlc_pkg::PRICE_BITS-1:0]    open_price;
  logic [ohlc_pkg::PRICE_BITS-1:0]    high_price;
  logic [ohlc_pkg::PRICE_BITS-1:0]    low_price;
  logic [ohlc_pkg::PRICE_BITS-1:0]    close_price;
  logic [ohlc_pkg::VOLUME_BITS-1:0]   bar_volume;
  logic [ohlc_pkg::TIME_BITS-1:0]     empty_periods;

  modport source (output valid, bar_time, open_price, high_price, low_price, close_price,
                  bar_volume, empty_periods, input ready);
  modport sink   (input valid, bar_time, open_price, high_price, low_price, close_price,
                  bar_volume, empty_periods, output ready);
endinterface

interface ohlc_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [ohlc_pkg::CFG_IDX_BITS-1:0]   index;
  logic [ohlc_pkg::CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[src/ohlc_bar_resampler_core.sv]
`timescale 1ns / 1ps
// OHLC bar resampler: 31-step restoring divider for the period index, with a
// bit-serial multiply for the bar start time running in the same steps.
// A bar is registered to the output on leaving the finish state, which holds while the
// output slot is full. One record at a time: a new record is taken only in idle, after
// the run and finish of the last; dropped records and flushes with no open bar start no run.
// Reset: asynchronous, active low; no bar open, period 60, no window bounds.
module ohlc_bar_resampler_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  ohlc_cfg_if.sink   cfg_i,
  ohlc_rec_if.sink   rec_i,
  ohlc_bar_if.source bar_o
);

  localparam int unsigned TB = ohlc_pkg::TIME_BITS;
  localparam int unsigned PB = ohlc_pkg::PERIOD_BITS;
  localparam int unsigned CB = $clog2(TB);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [CB-1:0] cnt_q, cnt_d;

  logic [PB-1:0] sample_period_q;
  logic [TB-1:0] window_start_q, window_end_q;

  logic                              bar_active_q, bar_active_d;
  logic [TB-1:0]                     bar_index_q;
  logic [ohlc_pkg::PRICE_BITS-1:0]   bar_open_q, bar_high_q, bar_low_q, bar_close_q;
  logic [ohlc_pkg::VOLUME_BITS-1:0]  bar_vol_q;

  logic                              kind_q;
  logic [ohlc_pkg::PRICE_BITS-1:0]   price_q;
  logic [ohlc_pkg::VOLUME_BITS-1:0]  vol_q;

  // divider and multiplier shift registers
  logic [TB-1:0] dq_q;
  logic [PB-1:0] rem_q;
  logic [TB-1:0] mc_q, acc_q;
  logic [PB-1:0] pser_q;

  logic          out_valid_q;
  logic [TB-1:0] out_time_q, out_empty_q;
  logic [ohlc_pkg::PRICE_BITS-1:0]  out_open_q, out_high_q, out_low_q, out_close_q;
  logic [ohlc_pkg::VOLUME_BITS-1:0] out_vol_q;

  logic [PB-1:0] period;
  logic          rec_acc, in_window, start_run;
  logic [PB:0]   rem_sh;
  logic          q_bit;
  logic          emit, stall, finish, fold, newer;
  logic [TB-1:0] empty;
  logic [ohlc_pkg::VOLUME_BITS:0] vol_sum;

  assign cfg_i.ready = 1'b1;
  assign rec_i.ready = (state_q == ST_IDLE);

  assign period    = (sample_period_q == '0) ? PB'(1) : sample_period_q;
  assign rec_acc   = rec_i.valid && rec_i.ready;
  assign in_window = (rec_i.record_time >= window_start_q) &&
                     ((window_end_q == '0) || (rec_i.record_time < window_end_q));
  assign start_run = rec_acc && ((rec_i.kind == ohlc_pkg::KIND_FLUSH) ? bar_active_q
                                                                       : in_window);

  assign rem_sh = {rem_q, dq_q[TB-1]};
  assign q_bit  = (rem_sh >= {1'b0, period});

  assign newer   = (dq_q > bar_index_q);
  assign empty   = dq_q - bar_index_q - TB'(1);
  assign emit    = (kind_q == ohlc_pkg::KIND_FLUSH) || (bar_active_q && newer);
  assign fold    = (kind_q == ohlc_pkg::KIND_TRADE) && bar_active_q && !newer;
  assign stall   = emit && out_valid_q && !bar_o.ready;
  assign finish  = (state_q == ST_DONE) && !stall;
  assign vol_sum = {1'b0, bar_vol_q} + {1'b0, vol_q};

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    bar_active_d = bar_active_q;
    case (state_q)
      ST_IDLE: begin
        if (start_run) begin
          state_d = ST_RUN;
          cnt_d   = CB'(TB - 1);
        end
      end
      ST_RUN: begin
        cnt_d = cnt_q - CB'(1);
        if (cnt_q == '0) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!stall) begin
          state_d      = ST_IDLE;
          bar_active_d = (kind_q == ohlc_pkg::KIND_TRADE);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      cnt_q           <= '0;
      bar_active_q    <= 1'b0;
      out_valid_q     <= 1'b0;
      sample_period_q <= ohlc_pkg::SAMPLE_PERIOD_RST;
      window_start_q  <= '0;
      window_end_q    <= '0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      bar_active_q <= bar_active_d;
      if (finish && emit) begin
        out_valid_q <= 1'b1;
      end else if (bar_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          ohlc_pkg::CFG_SAMPLE_PERIOD: sample_period_q <= cfg_i.data[PB-1:0];
          ohlc_pkg::CFG_WINDOW_START:  window_start_q  <= cfg_i.data[TB-1:0];
          ohlc_pkg::CFG_WINDOW_END:    window_end_q    <= cfg_i.data[TB-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    if (rec_acc) begin
      kind_q  <= rec_i.kind;
      price_q <= rec_i.price;
      vol_q   <= rec_i.volume;
      dq_q    <= rec_i.record_time;
      rem_q   <= '0;
      mc_q    <= bar_index_q;
      pser_q  <= period;
      acc_q   <= '0;
    end else if (state_q == ST_RUN) begin
      dq_q   <= {dq_q[TB-2:0], q_bit};
      rem_q  <= q_bit ? PB'(rem_sh - {1'b0, period}) : rem_sh[PB-1:0];
      acc_q  <= acc_q + (pser_q[0] ? mc_q : '0);
      mc_q   <= {mc_q[TB-2:0], 1'b0};
      pser_q <= {1'b0, pser_q[PB-1:1]};
    end

    if (finish && emit) begin
      out_time_q  <= acc_q;
      out_open_q  <= bar_open_q;
      out_high_q  <= bar_high_q;
      out_low_q   <= bar_low_q;
      out_close_q <= bar_close_q;
      out_vol_q   <= bar_vol_q;
      out_empty_q <= (kind_q == ohlc_pkg::KIND_FLUSH) ? '0 : empty;
    end

    if (finish) begin
      if (fold) begin
        if (price_q > bar_high_q) bar_high_q <= price_q;
        if (price_q < bar_low_q)  bar_low_q  <= price_q;
        bar_close_q <= price_q;
        bar_vol_q   <= vol_sum[ohlc_pkg::VOLUME_BITS] ? '1
                                                      : vol_sum[ohlc_pkg::VOLUME_BITS-1:0];
      end else if (kind_q == ohlc_pkg::KIND_TRADE) begin
        bar_index_q <= dq_q;
        bar_open_q  <= price_q;
        bar_high_q  <= price_q;
        bar_low_q   <= price_q;
        bar_close_q <= price_q;
        bar_vol_q   <= vol_q;
      end
    end
  end

  assign bar_o.valid         = out_valid_q;
  assign bar_o.bar_time      = out_time_q;
  assign bar_o.open_price    = out_open_q;
  assign bar_o.high_price    = out_high_q;
  assign bar_o.low_price     = out_low_q;
  assign bar_o.close_price   = out_close_q;
  assign bar_o.bar_volume    = out_vol_q;
  assign bar_o.empty_periods = out_empty_q;

`ifndef NO_ASSERTIONS
  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && cnt_q == '0) |=> (state_q == ST_DONE))
    else $error("divider run did not finish after last step");

  a_accept_no_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_acc |=> (state_q != ST_DONE))
    else $error("finish reached directly after transaction");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && stall) |=> (state_q == ST_DONE && $stable(bar_index_q)
                                       && $stable(bar_active_q)))
    else $error("bar state changed while output slot was full");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("bar emitted outside finish step");
`endif

endmodule

[bench/ohlc_bar_resampler_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for ohlc_bar_resampler_core: directed and random trade streams
// against an in-bench bar predictor, with random idle gaps on the record channel and ready stalls on the bar channel.
// Depends on ohlc_pkg, ohlc_if and the core.
module ohlc_bar_resampler_core_tb;

  localparam int unsigned TIME_BITS     = ohlc_pkg::TIME_BITS;
  localparam int unsigned PRICE_BITS    = ohlc_pkg::PRICE_BITS;
  localparam int unsigned VOLUME_BITS   = ohlc_pkg::VOLUME_BITS;
  localparam int unsigned PERIOD_BITS   = ohlc_pkg::PERIOD_BITS;
  localparam int unsigned CFG_IDX_BITS  = ohlc_pkg::CFG_IDX_BITS;
  localparam int unsigned CFG_DATA_BITS = ohlc_pkg::CFG_DATA_BITS;

  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
  localparam int SETTLE = 40;

  typedef struct packed {
    logic                   kind;
    logic [TIME_BITS-1:0]   record_time;
    logic [PRICE_BITS-1:0]  price;
    logic [VOLUME_BITS-1:0] volume;
  } rec_t;

  typedef struct packed {
    logic [TIME_BITS-1:0]   bar_time;
    logic [PRICE_BITS-1:0]  open_price;
    logic [PRICE_BITS-1:0]  high_price;
    logic [PRICE_BITS-1:0]  low_price;
    logic [PRICE_BITS-1:0]  close_price;
    logic [VOLUME_BITS-1:0] bar_volume;
    logic [TIME_BITS-1:0]   empty_periods;
  } bar_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                     cfg_valid = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic                     tr_valid = 1'b0;
  rec_t                     tr_rec = '0;
  logic                     bar_ready = 1'b0;

  ohlc_cfg_if cfg_if ();
  ohlc_rec_if rec_if ();
  ohlc_bar_if bar_if ();

  assign cfg_if.valid       = cfg_valid;
  assign cfg_if.index       = cfg_index;
  assign cfg_if.data        = cfg_data;
  assign rec_if.valid       = tr_valid;
  assign rec_if.kind        = tr_rec.kind;
  assign rec_if.record_time = tr_rec.record_time;
  assign rec_if.price       = tr_rec.price;
  assign rec_if.volume      = tr_rec.volume;
  assign bar_if.ready       = bar_ready;

  ohlc_bar_resampler_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .rec_i  (rec_if),
    .bar_o  (bar_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state and register copies
  logic [PERIOD_BITS-1:0] period_reg = ohlc_pkg::SAMPLE_PERIOD_RST;
  logic [TIME_BITS-1:0]   win_lo = '0;
  logic [TIME_BITS-1:0]   win_hi = '0;
  logic                   bar_live = 1'b0;
  logic [TIME_BITS-1:0]   live_idx = '0;
  logic [PRICE_BITS-1:0]  live_open = '0;
  logic [PRICE_BITS-1:0]  live_high = '0;
  logic [PRICE_BITS-1:0]  live_low = '0;
  logic [PRICE_BITS-1:0]  live_close = '0;
  logic [VOLUME_BITS-1:0] live_vol = '0;

  bar_t        bars_due[$];
  rec_t        pending[$];
  rec_t        cur_rec;
  bar_t        want;
  int unsigned recs_queued = 0;
  int unsigned recs_taken = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  bit          quiet = 1'b0;
  bit          failed = 1'b0;

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  function automatic void close_bar(input logic [31:0] per, input logic [TIME_BITS-1:0] gaps);
    bar_t b;
    logic [63:0] start;
    start = 64'(live_idx) * 64'(per);
    b.bar_time      = start[TIME_BITS-1:0];
    b.open_price    = live_open;
    b.high_price    = live_high;
    b.low_price     = live_low;
    b.close_price   = live_close;
    b.bar_volume    = live_vol;
    b.empty_periods = gaps;
    bars_due.insert(bars_due.size(), b);
  endfunction

  function automatic void fold_record(input rec_t r);
    logic [31:0]            per;
    logic [TIME_BITS-1:0]   idx;
    logic [VOLUME_BITS:0]   sum;
    per = (period_reg == '0) ? 32'd1 : 32'(period_reg);
    if (r.kind == ohlc_pkg::KIND_FLUSH) begin
      if (bar_live) begin
        close_bar(per, '0);
        bar_live = 1'b0;
      end
      return;
    end
    if (win_lo != '0 && r.record_time < win_lo) return;
    if (win_hi != '0 && r.record_time >= win_hi) return;
    idx = TIME_BITS'(32'(r.record_time) / per);
    if (!bar_live || idx > live_idx) begin
      if (bar_live) close_bar(per, idx - live_idx - 1'b1);
      bar_live   = 1'b1;
      live_idx   = idx;
      live_open  = r.price;
      live_high  = r.price;
      live_low   = r.price;
      live_close = r.price;
      live_vol   = r.volume;
      return;
    end
    if (r.price > live_high) live_high = r.price;
    if (r.price < live_low) live_low = r.price;
    live_close = r.price;
    sum = {1'b0, live_vol} + {1'b0, r.volume};
    live_vol = sum[VOLUME_BITS] ? '1 : sum[VOLUME_BITS-1:0];
  endfunction

  function automatic void check_field(input string name, input logic [63:0] exp_v,
                                      input logic [63:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_v, got_v);
      failed = 1'b1;
    end
  endfunction

  // record driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (tr_valid && rec_if.ready) begin
        fold_record(cur_rec);
        recs_taken++;
      end
      if (!tr_valid || rec_if.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          tr_valid <= 1'b0;
        end else if (pending.size() != 0) begin
          cur_rec = pending.pop_front();
          tr_rec <= cur_rec;
          tr_valid <= 1'b1;
          gap_left = idle_len();
        end else begin
          tr_valid <= 1'b0;
        end
      end
    end
  end

  // bar monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (bar_if.valid && bar_ready) begin
        if (bars_due.size() == 0) begin
          $display("%0t: unexpected bar transaction, bar_time 0x%0h close 0x%0h", $time,
                   bar_if.bar_time, bar_if.close_price);
          failed = 1'b1;
        end else begin
          want = bars_due.pop_front();
          check_field("bar_time", 64'(want.bar_time), 64'(bar_if.bar_time));
          check_field("open_price", 64'(want.open_price), 64'(bar_if.open_price));
          check_field("high_price", 64'(want.high_price), 64'(bar_if.high_price));
          check_field("low_price", 64'(want.low_price), 64'(bar_if.low_price));
          check_field("close_price", 64'(want.close_price), 64'(bar_if.close_price));
          check_field("bar_volume", 64'(want.bar_volume), 64'(bar_if.bar_volume));
          check_field("empty_periods", 64'(want.empty_periods),
                      64'(bar_if.empty_periods));
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        bar_ready <= 1'b0;
      end else begin
        bar_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = idle_len();
      end
    end
  end

  task automatic queue_rec(input logic kind, input logic [TIME_BITS-1:0] t,
                           input logic [PRICE_BITS-1:0] px, input logic [VOLUME_BITS-1:0] vol);
    rec_t r;
    r.kind        = kind;
    r.record_time = t;
    r.price       = px;
    r.volume      = vol;
    pending.insert(pending.size(), r);
    recs_queued++;
  endtask

  task automatic wait_drained();
    int unsigned n;
    while (recs_taken != recs_queued) @(posedge clk_i);
    n = 0;
    while (bars_due.size() != 0 && n < 4000) begin
      @(posedge clk_i);
      n++;
    end
    if (bars_due.size() != 0) begin
      $display("%0t: %0d predicted bars never arrived", $time, bars_due.size());
      failed = 1'b1;
      bars_due.delete();
    end
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do begin
      @(posedge clk_i);
    end while (!cfg_if.ready);
    case (idx)
      ohlc_pkg::CFG_SAMPLE_PERIOD: period_reg = value[PERIOD_BITS-1:0];
      ohlc_pkg::CFG_WINDOW_START:  win_lo = value[TIME_BITS-1:0];
      ohlc_pkg::CFG_WINDOW_END:    win_hi = value[TIME_BITS-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // upper data bits above the period field are junk and must be ignored
  task automatic program_regs(input logic [PERIOD_BITS-1:0] period,
                              input logic [TIME_BITS-1:0] lo, input logic [TIME_BITS-1:0] hi);
    logic [CFG_DATA_BITS-1:0] d;
    d = CFG_DATA_BITS'($urandom);
    d[PERIOD_BITS-1:0] = period;
    write_reg(ohlc_pkg::CFG_SAMPLE_PERIOD, d);
    write_reg(ohlc_pkg::CFG_WINDOW_START, lo);
    write_reg(ohlc_pkg::CFG_WINDOW_END, hi);
  endtask

  // mostly forward-moving trades in and across periods, with late, junk and flush records mixed in
  task automatic queue_session(input int unsigned n, input longint unsigned start,
                               input int unsigned per, input bit hold_midway);
    longint unsigned t;
    longint unsigned back;
    logic [PRICE_BITS-1:0]  level;
    logic [PRICE_BITS-1:0]  px;
    logic [VOLUME_BITS-1:0] vol;
    int unsigned r;
    t = start;
    level = $urandom;
    for (int unsigned i = 0; i < n; i++) begin
      if (hold_midway && i == n / 2) wait_drained();
      r = $urandom_range(0, 99);
      if (r < 6) begin
        queue_rec(ohlc_pkg::KIND_FLUSH, TIME_BITS'($urandom), $urandom,
                  VOLUME_BITS'({$urandom, $urandom}));
        continue;
      end
      if (r < 11) begin
        queue_rec(ohlc_pkg::KIND_TRADE, TIME_BITS'($urandom), $urandom,
                  VOLUME_BITS'({$urandom, $urandom}));
        continue;
      end
      r = $urandom_range(0, 99);
      if (r < 45) begin
        t += 64'($urandom_range(0, per / 3));
      end else if (r < 57) begin
        back = 64'($urandom_range(0, 2 * per));
        t = (t > back) ? t - back : '0;
      end else if (r < 80) begin
        t += 64'(per) * 64'($urandom_range(1, 4));
      end else if (r < 88) begin
        t += 64'($urandom_range(0, 5000000));
      end
      level = level + PRICE_BITS'($urandom_range(0, 64)) - PRICE_BITS'(32);
      r = $urandom_range(0, 99);
      if (r < 75) px = level;
      else if (r < 83) px = '0;
      else if (r < 91) px = '1;
      else px = $urandom;
      r = $urandom_range(0, 99);
      if (r < 70) vol = VOLUME_BITS'($urandom_range(0, 100000));
      else if (r < 85) vol = VOLUME_BITS'({$urandom, $urandom});
      else vol = '1 - VOLUME_BITS'($urandom_range(0, 1000));
      queue_rec(ohlc_pkg::KIND_TRADE, t[TIME_BITS-1:0], px, vol);
    end
  endtask

  initial begin
    int unsigned p;
    longint unsigned base;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: 60 s bars, no window
    queue_rec(ohlc_pkg::KIND_FLUSH, TIME_MAX, '1, '1);
    queue_rec(ohlc_pkg::KIND_TRADE, '0, '0, '0);
    queue_rec(ohlc_pkg::KIND_TRADE, 31'd59, '1, '1);
    queue_rec(ohlc_pkg::KIND_TRADE, 31'd30, 32'd5, 48'd1);
    queue_rec(ohlc_pkg::KIND_TRADE, 31'd60, 32'd7, 48'd3);
    queue_rec(ohlc_pkg::KIND_TRADE, 31'd600, 32'd9, 48'd4);
    queue_rec(ohlc_pkg::KIND_TRADE, 31'd10, '1, 48'd5);
    queue_rec(ohlc_pkg::KIND_FLUSH, 31'd123456, 32'hA5A5_A5A5, 48'h5A5A_5A5A_5A5A);
    queue_rec(ohlc_pkg::KIND_FLUSH, '0, '0, '0);
    queue_rec(ohlc_pkg::KIND_TRADE, TIME_MAX, 32'd1, 48'd1);
    queue_rec(ohlc_pkg::KIND_TRADE, '0, '0, 48'hFFFF_FFFF_FFFE);
    queue_rec(ohlc_pkg::KIND_TRADE, TIME_MAX, 32'd2, 48'd1);
    queue_rec(ohlc_pkg::KIND_FLUSH, '0, '0, '0);
    wait_drained();

    // zero period acts as one second; window 1000..1999
    program_regs('0, 31'd1000, 31'd2000);
    queue_rec(ohlc_pkg::KIND_TRADE, 31'd999, 32'd11, 48'd1);
    queue_rec(ohlc_pkg::KIND_TRADE, 31'd2000, 32'd12, 48'd1);
    queue_rec(ohlc_pkg::KIND_TRADE, '0, 32'd13, 48'd1);
    queue_rec(ohlc_pkg::KIND_TRADE, 31'd1000, 32'd100, 48'd5);
    queue_rec(ohlc_pkg::KIND_TRADE, 31'd1000, 32'd50, 48'd6);
    queue_rec(ohlc_pkg::KIND_TRADE, 31'd1999, 32'd300, 48'd7);
    queue_rec(ohlc_pkg::KIND_FLUSH, TIME_MAX, '1, '1);
    wait_drained();

    quiet = 1'b1;
    program_regs(17'd1, '0, '0);
    queue_session(50, 64'($urandom_range(0, 32'h7FFF_0000)), 1, 1'b0);
    wait_drained();
    quiet = 1'b0;

    program_regs(17'd86400, '0, TIME_MAX);
    queue_session(50, 64'($urandom_range(0, 32'h7FF0_0000)), 86400, 1'b0);
    wait_drained();

    base = 64'($urandom_range(0, 32'h7000_0000));
    program_regs(17'd15, TIME_BITS'(base + 100), TIME_BITS'(base + 1600));
    queue_session(50, base, 15, 1'b0);
    wait_drained();

    program_regs(17'd60, '0, '0);
    queue_session(60, 64'($urandom_range(0, 32'h7FFF_0000)), 60, 1'b1);
    wait_drained();

    program_regs('1, '0, '0);
    queue_session(40, 64'($urandom_range(0, 32'h7FF0_0000)), 131071, 1'b0);
    wait_drained();

    program_regs(17'd7, 31'h7FFF_FF00, '0);
    queue_session(50, 64'h7FFF_FEF0, 7, 1'b0);
    wait_drained();

    p = $urandom_range(1, 3600);
    program_regs(PERIOD_BITS'(p), '0, '0);
    queue_session(50, 64'($urandom_range(0, 32'h7FFF_0000)), p, 1'b1);
    wait_drained();

    program_regs(17'd2, '0, '0);
    queue_session(50, 64'($urandom_range(0, 32'h7FFF_0000)), 2, 1'b0);
    wait_drained();

    if (!failed) begin
      $display("PASS ohlc_bar_resampler_core");
    end else begin
      $display("FAIL ohlc_bar_resampler_core");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL ohlc_bar_resampler_core");
    $finish;
  end

endmodule

[files.f]
src/ohlc_pkg.sv
src/ohlc_if.sv
src/ohlc_bar_resampler_core.sv
bench/ohlc_bar_resampler_core_tb.sv
